FILE: hdl/tmpf_pkg.sv
package tmpf_pkg;

  localparam int DEF_PIXELS = 64;
  localparam int DEF_FRAMES = 8;
  localparam int SAMPLE_W   = 16;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/tmpf_if.sv
interface tmpf_in_if import tmpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface tmpf_out_if import tmpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median_value;
  logic                frame_end;

  modport source(output valid, output median_value, output frame_end, input ready);
  modport sink(input valid, input median_value, input frame_end, output ready);
endinterface

FILE: hdl/tmpf_ram.sv
module tmpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tmpf_ctrl.sv
module tmpf_ctrl import tmpf_pkg::*; #(
  parameter int FRAMES = DEF_FRAMES
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam int KW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [KW-1:0] k;
  logic [KW-1:0] k_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
          k_next     = '0;
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (k == KW'(FRAMES - 1)) begin
          state_next = S_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_READ && k == '0)
    else $error("read sequence did not begin after transaction");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded into occupied output register");

  a_finish_after_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(state) == S_WAIT || $past(state) == S_FINISH)
    else $error("result loaded before all reads were sorted");

endmodule

FILE: hdl/tmpf_datapath.sv
module tmpf_datapath import tmpf_pkg::*; #(
  parameter int PIXELS = DEF_PIXELS,
  parameter int FRAMES = DEF_FRAMES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] median_value,
  output logic                frame_end
);

  localparam int DEPTH = PIXELS * FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int PW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CW    = (FW > AW) ? FW : AW;

  logic [AW-1:0]       wptr;
  logic [FW-1:0]       fill;
  logic [PW-1:0]       pix;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       rd_addr_q;
  logic                issue_q;
  logic                last;
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] ins_val;
  logic [SAMPLE_W-1:0] median;
  logic [SAMPLE_W-1:0] sorted      [FRAMES];
  logic [SAMPLE_W-1:0] sorted_next [FRAMES];
  logic [FRAMES-1:0]   gt;

  tmpf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.start),
    .waddr(wptr),
    .wdata(sample),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      fill    <= '0;
      pix     <= '0;
      issue_q <= 1'b0;
    end else begin
      issue_q <= cmd.issue;
      if (cmd.start) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
        pix  <= (pix == PW'(PIXELS - 1)) ? '0 : pix + 1'b1;
        if (fill != FW'(DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (cmd.start) begin
      rd_addr <= AW'(pix);
      last    <= (pix == PW'(PIXELS - 1));
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + AW'(PIXELS);
    end
  end

  // Entries past the fill count were never written and read as zero.
  assign ins_val = (CW'(rd_addr_q) < CW'(fill)) ? rdata : '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_sort
    assign gt[i] = sorted[i] > ins_val;
    if (i == 0) begin : g_head
      assign sorted_next[i] = gt[i] ? ins_val : sorted[i];
    end else begin : g_body
      assign sorted_next[i] = !gt[i] ? sorted[i] :
                              (gt[i-1] ? sorted[i-1] : ins_val);
    end
    always_ff @(posedge clk) begin
      if (cmd.start) begin
        sorted[i] <= '1;
      end else if (issue_q) begin
        sorted[i] <= sorted_next[i];
      end
    end
  end

  if ((FRAMES % 2) == 0) begin : g_even
    logic [SAMPLE_W:0] mid_sum;
    assign mid_sum = {1'b0, sorted[FRAMES/2]} + {1'b0, sorted[FRAMES/2-1]};
    assign median  = mid_sum[SAMPLE_W:1];
  end else begin : g_odd
    assign median = sorted[FRAMES/2];
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      median_value <= median;
      frame_end    <= last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(fill) <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    cmd.start && fill != FW'(DEPTH) |=> fill == $past(fill) + 1'b1)
    else $error("fill count missed a write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_value) && $stable(frame_end))
    else $error("stalled result transaction changed");

endmodule

FILE: hdl/temporal_median_pixel_filter_core.sv
// Channel   Role    Payload                     Transfer
// samples   sink    sample[15:0]                valid & ready
// results   source  median_value[15:0], frame_end  valid & ready
//
// Each transaction runs from acceptance to a loaded result in these steps:
// one write, FRAMES reads through the single frame-store read port, a wait
// state for the registered read data and one load of the output register.
// Input is taken again once the result sits in the output register.
// Reset needs no clearing pass: a fill counter makes unwritten store
// entries read as zero. A stalled output holds the block in its final state.
module temporal_median_pixel_filter_core import tmpf_pkg::*; #(
  parameter int PIXELS = DEF_PIXELS,
  parameter int FRAMES = DEF_FRAMES
) (
  input logic              clk,
  input logic              rst,
  tmpf_in_if.sink          samples,
  tmpf_out_if.source       results
);

  cmd_t cmd;
  sts_t sts;

  tmpf_ctrl #(
    .FRAMES(FRAMES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  tmpf_datapath #(
    .PIXELS(PIXELS),
    .FRAMES(FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .sample      (samples.sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .median_value(results.median_value),
    .frame_end   (results.frame_end)
  );

endmodule

FILE: tb/tmpf_median_checker.sv
`timescale 1ns / 1ps

module tmpf_median_checker import tmpf_pkg::*; #(
  parameter int PIXELS = DEF_PIXELS,
  parameter int FRAMES = DEF_FRAMES
) (
  input  logic clk,
  input  logic rst,
  tmpf_in_if   samples,
  tmpf_out_if  results,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] median;
    logic                frame_end;
  } pixel_median_t;

  logic [SAMPLE_W-1:0] frame_store [PIXELS*FRAMES];
  int unsigned         oldest_slot;
  int unsigned         pixel_pos;
  pixel_median_t       pending_medians [$];

  function automatic pixel_median_t store_and_median(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] vals [FRAMES];
    logic [SAMPLE_W-1:0] key;
    logic [SAMPLE_W:0]   mid_sum;
    pixel_median_t       r;
    int                  j;
    frame_store[oldest_slot*PIXELS + pixel_pos] = s;
    for (int i = 0; i < FRAMES; i++) vals[i] = frame_store[i*PIXELS + pixel_pos];
    for (int i = 1; i < FRAMES; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (FRAMES % 2 == 0) begin
      mid_sum  = {1'b0, vals[FRAMES/2]} + {1'b0, vals[FRAMES/2-1]};
      r.median = mid_sum[SAMPLE_W:1];
    end else begin
      r.median = vals[FRAMES/2];
    end
    r.frame_end = (pixel_pos == PIXELS - 1);
    if (r.frame_end) begin
      pixel_pos   = 0;
      oldest_slot = (oldest_slot == FRAMES - 1) ? 0 : oldest_slot + 1;
    end else begin
      pixel_pos++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_median_t want;
    if (rst) begin
      for (int i = 0; i < PIXELS*FRAMES; i++) frame_store[i] = '0;
      oldest_slot = 0;
      pixel_pos   = 0;
      pending_medians.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected result transaction median=%0d frame_end=%0b",
                   $time, results.median_value, results.frame_end);
          mismatches++;
        end else begin
          want = pending_medians.pop_front();
          if (results.median_value !== want.median) begin
            $display("%0t: median_value expected %0d actual %0d",
                     $time, want.median, results.median_value);
            mismatches++;
          end
          if (results.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.frame_end, results.frame_end);
            mismatches++;
          end
        end
      end
      if (samples.valid && samples.ready)
        pending_medians.push_back(store_and_median(samples.sample));
      outstanding = pending_medians.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tmpf_pkg::*;

  localparam int PIXELS       = DEF_PIXELS;
  localparam int FRAMES       = DEF_FRAMES;
  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT  = 5000;

  logic clk;
  logic rst;

  tmpf_in_if  samples_if ();
  tmpf_out_if results_if ();

  int                  src_idle_pct;
  int                  snk_idle_pct;
  int                  median_errors;
  int                  medians_due;
  int                  stall_cycles;
  int                  sent;
  logic [SAMPLE_W-1:0] pixel_base [PIXELS];

  temporal_median_pixel_filter_core #(
    .PIXELS(PIXELS),
    .FRAMES(FRAMES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .results(results_if)
  );

  tmpf_median_checker #(
    .PIXELS(PIXELS),
    .FRAMES(FRAMES)
  ) u_median_chk (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples_if),
    .results    (results_if),
    .mismatches (median_errors),
    .outstanding(medians_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic put_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= v;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_medians();
    samples_if.valid <= 1'b0;
    @(negedge clk);
    while (medians_due != 0) @(negedge clk);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed [20];
    logic [SAMPLE_W-1:0] v;
    int                  pix;
    directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                 16'h3333, 16'hCCCC, 16'h0000, 16'hFFFF, 16'h1234, 16'hEDCB,
                 16'h0002, 16'hFFFD};
    rst               = 1'b1;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    src_idle_pct      = 20;
    snk_idle_pct      = 72;
    sent              = 0;
    for (int i = 0; i < PIXELS; i++) pixel_base[i] = SAMPLE_W'($urandom_range(16'hFFFF));
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) put_sample(directed[i]);
    drain_medians();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_medians();
        src_idle_pct = 72;
        snk_idle_pct = 20;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_medians();
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      pix = sent % PIXELS;
      case ($urandom_range(9))
        0:       v = '0;
        1:       v = '1;
        2, 3:    v = SAMPLE_W'($urandom_range(16'hFFFF));
        default: v = SAMPLE_W'(pixel_base[pix] + $urandom_range(64) - 32);
      endcase
      put_sample(v);
    end

    drain_medians();
    repeat (FRAMES + 3 + 8) @(negedge clk);

    $display("Covered %0d samples, %0d frames of %0d pixels, oldest slot wrapping every %0d",
             sent, sent / PIXELS, PIXELS, FRAMES);
    $display("with sender stalls, receiver stalls, full drains and back-to-back flow");
    if (median_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
